// ===== sv/monotonic_ulid_encoder_core_macros.svh =====
// Assertion macros shared by the checker of the ULID encoder.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef MONOTONIC_ULID_ENCODER_CORE_MACROS_SVH
`define MONOTONIC_ULID_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MUE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mue check failed");

// Next-cycle implication, checked outside reset.
`define MUE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mue check failed");

`endif

// ===== sv/mue_pkg.sv =====
// Types, constants and the character table of the monotonic ULID encoder.
// No dependencies.
package mue_pkg;

  localparam int unsigned TIME_W   = 48;
  localparam int unsigned RHIGH_W  = 16;
  localparam int unsigned RLOW_W   = 64;
  localparam int unsigned RAND_W   = RHIGH_W + RLOW_W;
  localparam int unsigned ULID_W   = TIME_W + RAND_W;
  localparam int unsigned PADDED_W = ULID_W + 2;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned DIGIT_W  = 5;
  localparam int unsigned ULID_CHARS = 26;
  localparam logic [4:0]  LAST_IDX = 5'(ULID_CHARS - 1);

  typedef struct packed {
    logic              retry;
    logic [ULID_W-1:0] ulid;
  } ent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  localparam logic [CHAR_W-1:0] CROCKFORD [32] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46,
    7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4D, 7'h4E, 7'h50, 7'h51,
    7'h52, 7'h53, 7'h54, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A
  };

endpackage

// ===== sv/mue_front.sv =====
// Front end: holds the last time and random value, classifies each item
// as new time, same-time increment or exhausted, and forms a queue entry. Uses mue_pkg.
module mue_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [mue_pkg::TIME_W-1:0]     time_ms,
  input  logic [mue_pkg::RHIGH_W-1:0]    fresh_random_high,
  input  logic [mue_pkg::RLOW_W-1:0]     fresh_random_low,
  output mue_pkg::ent_t                  entry
);

  logic [mue_pkg::TIME_W-1:0] last_time_r, last_time_nxt;
  logic [mue_pkg::RAND_W-1:0] rand_r, rand_nxt;
  logic [mue_pkg::RAND_W-1:0] rand_inc;
  logic                       same_time;
  logic                       exhausted;

  assign same_time = (time_ms == last_time_r);
  assign exhausted = &rand_r;
  assign rand_inc  = rand_r + mue_pkg::RAND_W'(1);

  always_comb begin
    last_time_nxt = last_time_r;
    rand_nxt      = rand_r;
    entry.retry   = 1'b0;
    entry.ulid    = {time_ms, fresh_random_high, fresh_random_low};
    if (!same_time) begin
      last_time_nxt = time_ms;
      rand_nxt      = {fresh_random_high, fresh_random_low};
    end else if (exhausted) begin
      // The state stays as it is; the item only reports a retry.
      entry.retry = 1'b1;
    end else begin
      rand_nxt   = rand_inc;
      entry.ulid = {last_time_r, rand_inc};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      rand_r      <= '0;
    end else if (accept) begin
      last_time_r <= last_time_nxt;
      rand_r      <= rand_nxt;
    end
  end

endmodule

// ===== sv/mue_queue.sv =====
// Short register queue between the front and back ends of the ULID encoder.
// Uses mue_pkg for the entry and status types.
module mue_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  mue_pkg::ent_t   wr_data,
  input  logic            rd_en,
  output mue_pkg::ent_t   rd_data,
  output mue_pkg::qstat_t stat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  mue_pkg::ent_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign rd_data    = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CW'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== sv/mue_back.sv =====
// Back end: takes one queue entry at a time and shifts it out as Base32
// characters, one per accepted result, or a single retry status. Uses mue_pkg.
module mue_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mue_pkg::ent_t                 q_data,
  input  logic                          q_empty,
  output logic                          q_rd,
  input  logic                          pop,
  output logic                          empty,
  output logic [mue_pkg::CHAR_W-1:0]    char_code,
  output logic                          status,
  output logic                          last_flag
);

  logic                           busy_r, busy_nxt;
  logic                           retry_r, retry_nxt;
  logic [mue_pkg::PADDED_W-1:0]   sh_r, sh_nxt;
  logic [4:0]                     idx_r, idx_nxt;
  logic                           take;
  logic                           is_last;

  assign is_last = retry_r || (idx_r == mue_pkg::LAST_IDX);
  assign take    = busy_r && pop;
  // A new entry loads as soon as the current one delivers its final result.
  assign q_rd    = !q_empty && (!busy_r || (take && is_last));

  assign empty     = !busy_r;
  assign status    = retry_r;
  assign last_flag = is_last;
  assign char_code = retry_r ? '0
                   : mue_pkg::CROCKFORD[sh_r[mue_pkg::PADDED_W-1 -: mue_pkg::DIGIT_W]];

  always_comb begin
    busy_nxt  = busy_r;
    retry_nxt = retry_r;
    sh_nxt    = sh_r;
    idx_nxt   = idx_r;
    if (q_rd) begin
      busy_nxt  = 1'b1;
      retry_nxt = q_data.retry;
      // Two zero pad bits sit above the identifier's top bit.
      sh_nxt    = {2'b00, q_data.ulid};
      idx_nxt   = '0;
    end else if (take) begin
      if (is_last) begin
        busy_nxt = 1'b0;
      end else begin
        sh_nxt  = sh_r << mue_pkg::DIGIT_W;
        idx_nxt = idx_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      retry_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      retry_r <= retry_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

endmodule

// ===== sv/monotonic_ulid_encoder_core.sv =====
// Monotonic ULID encoder: 26 Base32 characters per item, or one retry status.
// An item's first character passes through the entry queue and the back end's shift register
// and waits while the back end is busy; characters leave one per cycle while out_pop is high;
// the front end takes a new item every cycle while the entry queue has room.
// Reset (synchronous, rst_n low) clears the stored time and random value and empties the queue.
module monotonic_ulid_encoder_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [mue_pkg::TIME_W-1:0]    in_time_ms,
  input  logic [mue_pkg::RHIGH_W-1:0]   in_fresh_random_high,
  input  logic [mue_pkg::RLOW_W-1:0]    in_fresh_random_low,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [mue_pkg::CHAR_W-1:0]    out_char_code,
  output logic                          out_status,
  output logic                          out_last_flag
);

  mue_pkg::ent_t   fe_entry;
  mue_pkg::ent_t   q_data;
  mue_pkg::qstat_t q_stat;
  logic            accept;
  logic            q_rd;

  assign in_full = q_stat.full;
  assign accept  = in_push && !q_stat.full;

  mue_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (accept),
    .time_ms           (in_time_ms),
    .fresh_random_high (in_fresh_random_high),
    .fresh_random_low  (in_fresh_random_low),
    .entry             (fe_entry)
  );

  mue_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data (fe_entry),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .stat    (q_stat)
  );

  mue_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_data),
    .q_empty   (q_stat.empty),
    .q_rd      (q_rd),
    .pop       (out_pop),
    .empty     (out_empty),
    .char_code (out_char_code),
    .status    (out_status),
    .last_flag (out_last_flag)
  );

endmodule

// ===== sv/mue_checker.sv =====
// Port-level checks for the ULID encoder, bound to the top level.
// Depends on monotonic_ulid_encoder_core_macros.svh.
`include "monotonic_ulid_encoder_core_macros.svh"

module mue_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_empty,
  input logic       out_pop,
  input logic [6:0] out_char_code,
  input logic       out_status,
  input logic       out_last_flag
);

  // A retry is a single result on its own.
  `MUE_ASSERT_IMP(a_retry_last, !out_empty && out_status, out_last_flag)
  `MUE_ASSERT_IMP(a_retry_zero, !out_empty && out_status, out_char_code == 7'd0)
  // Character results are always printable Base32 characters.
  `MUE_ASSERT_IMP(a_char_range, !out_empty && !out_status,
                  out_char_code >= 7'h30 && out_char_code <= 7'h5A)
  `MUE_ASSERT_NEXT(a_hold, !out_empty && !out_pop,
                   !out_empty && $stable(out_char_code) && $stable(out_last_flag))

endmodule

bind monotonic_ulid_encoder_core mue_checker u_mue_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_empty     (out_empty),
  .out_pop       (out_pop),
  .out_char_code (out_char_code),
  .out_status    (out_status),
  .out_last_flag (out_last_flag)
);

// ===== test/monotonic_ulid_encoder_core_checker.sv =====
// Checker for the monotonic ULID encoder: follows the item and result channels,
// predicts the characters of every identifier and compares them in order.
// Depends on mue_pkg for widths; instantiated by monotonic_ulid_encoder_core_tb.
`timescale 1ns / 1ps

module monotonic_ulid_encoder_core_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  input  logic                        in_full,
  input  logic [mue_pkg::TIME_W-1:0]  in_time_ms,
  input  logic [mue_pkg::RHIGH_W-1:0] in_fresh_random_high,
  input  logic [mue_pkg::RLOW_W-1:0]  in_fresh_random_low,
  input  logic                        out_empty,
  input  logic                        out_pop,
  input  logic [mue_pkg::CHAR_W-1:0]  out_char_code,
  input  logic                        out_status,
  input  logic                        out_last_flag,
  output int                          fail_count,
  output int                          pending
);

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RETRY = 1'b1;

  typedef struct packed {
    logic [mue_pkg::CHAR_W-1:0] char_code;
    logic                       status;
    logic                       last_flag;
  } ulid_char_t;

  logic [mue_pkg::TIME_W-1:0] last_stamp;
  logic [mue_pkg::RAND_W-1:0] entropy;
  ulid_char_t                 char_q[$];

  // Crockford digits: 0-9, then letters with I, L, O and U left out.
  function automatic logic [mue_pkg::CHAR_W-1:0] base32_char(
    input logic [mue_pkg::DIGIT_W-1:0] d);
    logic [mue_pkg::CHAR_W-1:0] code;
    if (d < 10) begin
      code = 7'h30 + d;
    end else begin
      code = 7'h37 + d + (d >= 18) + (d >= 20) + (d >= 22) + (d >= 27);
    end
    return code;
  endfunction

  task automatic predict_ulid(input logic [mue_pkg::TIME_W-1:0]  stamp,
                              input logic [mue_pkg::RHIGH_W-1:0] fresh_hi,
                              input logic [mue_pkg::RLOW_W-1:0]  fresh_lo);
    logic [mue_pkg::PADDED_W-1:0] ident;
    ulid_char_t                   ch;
    int                           k;
    if (stamp == last_stamp && &entropy) begin
      // The random space of this millisecond is used up; state stays as it is.
      ch.char_code = '0;
      ch.status    = STATUS_RETRY;
      ch.last_flag = 1'b1;
      char_q.push_back(ch);
    end else begin
      if (stamp != last_stamp) begin
        last_stamp = stamp;
        entropy    = {fresh_hi, fresh_lo};
      end else begin
        entropy = entropy + 1'b1;
      end
      ident = {2'b00, last_stamp, entropy};
      for (k = 0; k < mue_pkg::ULID_CHARS; k++) begin
        ch.char_code = base32_char(
          ident[mue_pkg::DIGIT_W*(mue_pkg::ULID_CHARS-1-k) +: mue_pkg::DIGIT_W]);
        ch.status    = STATUS_OK;
        ch.last_flag = (k == mue_pkg::ULID_CHARS - 1);
        char_q.push_back(ch);
      end
    end
  endtask

  always @(posedge clk) begin
    ulid_char_t want;
    if (!rst_n) begin
      last_stamp = '0;
      entropy    = '0;
      char_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (in_push && !in_full) begin
        predict_ulid(in_time_ms, in_fresh_random_high, in_fresh_random_low);
      end
      if (out_pop && !out_empty) begin
        if (char_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got char %h status %b last %b",
                   $time, out_char_code, out_status, out_last_flag);
          fail_count <= fail_count + 1;
        end else begin
          want = char_q.pop_front();
          if (want.char_code !== out_char_code || want.status !== out_status ||
              want.last_flag !== out_last_flag) begin
            $display("%0t: result mismatch: expected char %h status %b last %b,",
                     $time, want.char_code, want.status, want.last_flag);
            $display("%0t:   got char %h status %b last %b",
                     $time, out_char_code, out_status, out_last_flag);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= char_q.size();
    end
  end

endmodule

// ===== test/monotonic_ulid_encoder_core_tb.sv =====
// Testbench top for monotonic_ulid_encoder_core: drives items in bursts, stalls the
// result side, and takes its verdict from monotonic_ulid_encoder_core_checker.
// Depends on mue_pkg, the encoder RTL and the checker module.
`timescale 1ns / 1ps

module monotonic_ulid_encoder_core_tb;

  localparam int ITEM_COUNT     = 430;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 40;

  logic                        clk                  = 1'b0;
  logic                        rst_n                = 1'b0;
  logic                        in_push              = 1'b0;
  logic                        in_full;
  logic [mue_pkg::TIME_W-1:0]  in_time_ms           = '0;
  logic [mue_pkg::RHIGH_W-1:0] in_fresh_random_high = '0;
  logic [mue_pkg::RLOW_W-1:0]  in_fresh_random_low  = '0;
  logic                        out_empty;
  logic                        out_pop              = 1'b0;
  logic [mue_pkg::CHAR_W-1:0]  out_char_code;
  logic                        out_status;
  logic                        out_last_flag;

  int                          fail_count;
  int                          pending;
  int                          items_sent  = 0;
  int                          burst_left  = 0;
  int                          stall_left  = 0;
  int                          calm_left   = 0;
  int                          idle_cycles = 0;
  logic [mue_pkg::TIME_W-1:0]  prev_time   = '0;

  monotonic_ulid_encoder_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_time_ms           (in_time_ms),
    .in_fresh_random_high (in_fresh_random_high),
    .in_fresh_random_low  (in_fresh_random_low),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_char_code        (out_char_code),
    .out_status           (out_status),
    .out_last_flag        (out_last_flag)
  );

  monotonic_ulid_encoder_core_checker ulid_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_time_ms           (in_time_ms),
    .in_fresh_random_high (in_fresh_random_high),
    .in_fresh_random_low  (in_fresh_random_low),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_char_code        (out_char_code),
    .out_status           (out_status),
    .out_last_flag        (out_last_flag),
    .fail_count           (fail_count),
    .pending              (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Half the new times move forward a little, half land anywhere in the 48-bit range.
  function automatic logic [mue_pkg::TIME_W-1:0] pick_time();
    logic [63:0] r;
    r = rand64();
    if (r[63]) begin
      return prev_time + mue_pkg::TIME_W'($urandom_range(1, 1000));
    end
    return r[mue_pkg::TIME_W-1:0];
  endfunction

  // Offers one item and returns at the edge where it is taken.
  task automatic push_item(input logic [mue_pkg::TIME_W-1:0]  stamp,
                           input logic [mue_pkg::RHIGH_W-1:0] fresh_hi,
                           input logic [mue_pkg::RLOW_W-1:0]  fresh_lo);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_push              <= 1'b1;
    in_time_ms           <= stamp;
    in_fresh_random_high <= fresh_hi;
    in_fresh_random_low  <= fresh_lo;
    @(posedge clk);
    while (in_full) @(posedge clk);
    burst_left--;
    items_sent++;
    prev_time = stamp;
  endtask

  // Result side: mostly random stalls, with stretches that pop every cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop    <= 1'b0;
      stall_left <= 0;
      calm_left  <= 0;
    end else if (calm_left != 0) begin
      calm_left <= calm_left - 1;
      out_pop   <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_pop    <= 1'b0;
    end else begin
      out_pop <= 1'b1;
      case ($urandom_range(0, 9))
        0: calm_left <= $urandom_range(20, 120);
        1, 2, 3: stall_left <= $urandom_range(1, 12);
        default: ;
      endcase
    end
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int                          sel;
    int                          run_len;
    int                          k;
    logic [63:0]                 wide;
    logic [mue_pkg::TIME_W-1:0]  run_time;
    logic [mue_pkg::RHIGH_W-1:0] run_hi;
    logic [mue_pkg::RLOW_W-1:0]  run_lo;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // A time of zero right after reset matches the cleared state and increments.
    push_item('0, '1, '1);
    push_item('0, '0, '0);
    // Largest time with an all-ones random value, then exhaustion twice.
    push_item('1, '1, '1);
    push_item('1, '0, '0);
    push_item('1, 16'h1234, 64'h1);
    // Backward step to zero stores the fresh value again.
    push_item('0, '0, '0);
    push_item('0, '1, '1);
    // Carry from the low 64 bits into the high 16 bits.
    push_item(48'h1, 16'h1234, '1);
    push_item(48'h1, '0, '0);
    push_item(48'hAAAA_AAAA_AAAA, 16'h5555, 64'h5555_5555_5555_5555);
    push_item(48'h5555_5555_5555, 16'hAAAA, 64'hAAAA_AAAA_AAAA_AAAA);
    push_item(48'h5555_5555_5554, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFE);
    push_item(48'h5555_5555_5554, '0, '0);
    push_item(48'h5555_5555_5554, '0, '0);
    // Walk up to the top of the random space and hit it.
    push_item(48'h8000_0000_0000, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFE);
    push_item(48'h8000_0000_0000, '0, '0);
    push_item(48'h8000_0000_0000, '0, '0);
    push_item(48'h8000_0000_0001, 16'h8000, 64'h8000_0000_0000_0001);

    while (items_sent < ITEM_COUNT) begin
      sel    = $urandom_range(0, 99);
      run_hi = 16'($urandom);
      run_lo = rand64();
      if (sel < 40) begin
        run_time = pick_time();
        run_len  = $urandom_range(1, 8);
      end else if (sel < 55) begin
        // Low half close to all ones so the run carries into the high half.
        run_time = pick_time();
        run_lo   = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
        run_len  = $urandom_range(2, 6);
      end else if (sel < 65) begin
        // Close to the top of the random space so the run ends in retries.
        run_time = pick_time();
        run_hi   = '1;
        run_lo   = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 2));
        run_len  = $urandom_range(2, 6);
      end else if (sel < 75) begin
        run_time = $urandom_range(0, 1) ? prev_time + 1'b1 : prev_time - 1'b1;
        run_len  = 1;
      end else if (sel < 88) begin
        wide     = rand64();
        run_time = wide[mue_pkg::TIME_W-1:0];
        run_len  = 1;
      end else begin
        run_time = prev_time;
        run_len  = $urandom_range(1, 3);
      end
      for (k = 0; k < run_len && items_sent < ITEM_COUNT; k++) begin
        if (k == 0) begin
          push_item(run_time, run_hi, run_lo);
        end else begin
          push_item(run_time, 16'($urandom), rand64());
        end
      end
    end

    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
